// File: design/gdc_pkg.sv
package gdc_pkg;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [13:0] ref_year;
    logic [3:0]  ref_month;
    logic [4:0]  ref_day;
  } gdc_in_t;

  typedef struct packed {
    logic       date_valid;
    logic       ref_valid;
    logic [8:0] day_of_year;
    logic [4:0] days_in_month;
    logic [8:0] days_in_year;
    logic [2:0] weekday;
    logic [1:0] ordering;
  } gdc_out_t;

  typedef enum logic [1:0] {
    ORD_BEFORE  = 2'd0,
    ORD_EQUAL   = 2'd1,
    ORD_AFTER   = 2'd2,
    ORD_INVALID = 2'd3
  } gdc_order_e;

  localparam logic [13:0] YEAR_MIN     = 14'd1600;
  localparam logic [13:0] YEAR_MAX     = 14'd9999;
  localparam logic [3:0]  MONTH_FEB    = 4'd2;
  localparam logic [3:0]  MONTH_DEC    = 4'd12;
  // floor(x/100) = (x*5243) >> 19 for every 14-bit x
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;
  localparam int          PROD100_W    = 27;
  // floor(s/7) = (s*74899) >> 19 for s below 14979
  localparam logic [16:0] DIV7_MUL     = 17'd74899;
  localparam int          DIV7_SHIFT   = 19;
  localparam int          PROD7_W      = 31;
  localparam logic [13:0] WDAY_OFFSET  = 14'd5;

  // Stage 1 -> stage 2
  typedef struct packed {
    gdc_in_t               req;
    logic [PROD100_W-1:0]  y_prod;
    logic [PROD100_W-1:0]  r_prod;
    logic [PROD100_W-1:0]  p_prod;
    logic                  lt;
    logic                  eq;
  } gdc_s1_t;

  // Stage 2 -> stage 3
  typedef struct packed {
    logic       date_valid;
    logic       ref_valid;
    logic [8:0] doy;
    logic [4:0] dim;
    logic [8:0] diy;
    logic [13:0] cnt;
    gdc_order_e ord;
  } gdc_s2_t;

  function automatic logic [4:0] month_days(logic [3:0] m, logic leap);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      MONTH_FEB:                                   len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] month_start(logic [3:0] m);
    logic [8:0] s;
    unique case (m)
      4'd2:    s = 9'd31;
      4'd3:    s = 9'd59;
      4'd4:    s = 9'd90;
      4'd5:    s = 9'd120;
      4'd6:    s = 9'd151;
      4'd7:    s = 9'd181;
      4'd8:    s = 9'd212;
      4'd9:    s = 9'd243;
      4'd10:   s = 9'd273;
      4'd11:   s = 9'd304;
      4'd12:   s = 9'd334;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  // q is floor(y/100)
  function automatic logic is_leap(logic [13:0] y, logic [7:0] q);
    logic cent;
    cent = ((14'(q) * 14'd100) == y);
    return (y[1:0] == 2'b00) && (!cent || (q[1:0] == 2'b00));
  endfunction

  function automatic logic date_ok(logic [13:0] y, logic [3:0] m, logic [4:0] d,
                                   logic leap);
    return (y >= YEAR_MIN) && (y <= YEAR_MAX) && (m != 4'd0) && (m <= MONTH_DEC)
        && (d != 5'd0) && (d <= month_days(m, leap));
  endfunction

endpackage

// File: design/gdc_div_stage.sv
module gdc_div_stage (
  input  logic             clk_i,
  input  logic             en_i,
  input  gdc_pkg::gdc_in_t req_i,
  output gdc_pkg::gdc_s1_t s1_o
);
  import gdc_pkg::*;

  logic [13:0] yy;
  logic [13:0] p;
  gdc_s1_t     s1_d, s1_q;

  always_comb begin
    yy = req_i.year - YEAR_MIN;
    p  = yy - 14'd1;
    s1_d.req    = req_i;
    s1_d.y_prod = PROD100_W'(req_i.year) * PROD100_W'(DIV100_MUL);
    s1_d.r_prod = PROD100_W'(req_i.ref_year) * PROD100_W'(DIV100_MUL);
    s1_d.p_prod = PROD100_W'(p) * PROD100_W'(DIV100_MUL);
    s1_d.lt = {req_i.year, req_i.month, req_i.day}
            < {req_i.ref_year, req_i.ref_month, req_i.ref_day};
    s1_d.eq = {req_i.year, req_i.month, req_i.day}
           == {req_i.ref_year, req_i.ref_month, req_i.ref_day};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
    end
  end

  assign s1_o = s1_q;

endmodule

// File: design/gdc_cal_stage.sv
module gdc_cal_stage (
  input  logic             clk_i,
  input  logic             en_i,
  input  gdc_pkg::gdc_s1_t s1_i,
  output gdc_pkg::gdc_s2_t s2_o
);
  import gdc_pkg::*;

  logic [7:0]  qy, qr, qp;
  logic        leap_y, leap_r;
  logic [13:0] yy, p;
  logic [11:0] leaps;
  gdc_s2_t     s2_d, s2_q;

  always_comb begin
    qy = s1_i.y_prod[DIV100_SHIFT +: 8];
    qr = s1_i.r_prod[DIV100_SHIFT +: 8];
    qp = s1_i.p_prod[DIV100_SHIFT +: 8];
    leap_y = is_leap(s1_i.req.year, qy);
    leap_r = is_leap(s1_i.req.ref_year, qr);
    yy = s1_i.req.year - YEAR_MIN;
    p  = yy - 14'd1;
    // leap years in [1600, year): p/4 - p/100 + p/400 + 1
    if (yy == 14'd0) begin
      leaps = 12'd0;
    end else begin
      leaps = p[13:2] - 12'(qp) + 12'(qp[7:2]) + 12'd1;
    end

    s2_d.date_valid = date_ok(s1_i.req.year, s1_i.req.month, s1_i.req.day, leap_y);
    s2_d.ref_valid  = date_ok(s1_i.req.ref_year, s1_i.req.ref_month,
                              s1_i.req.ref_day, leap_r);
    s2_d.doy = month_start(s1_i.req.month) + 9'(s1_i.req.day)
             + 9'((s1_i.req.month > MONTH_FEB) && leap_y);
    s2_d.dim = month_days(s1_i.req.month, leap_y);
    s2_d.diy = leap_y ? 9'd366 : 9'd365;
    // 365 = 1 mod 7, so one per elapsed year is enough
    s2_d.cnt = 14'(s2_d.doy) + yy + 14'(leaps) + WDAY_OFFSET;

    if (!(s2_d.date_valid && s2_d.ref_valid)) begin
      s2_d.ord = ORD_INVALID;
    end else if (s1_i.lt) begin
      s2_d.ord = ORD_BEFORE;
    end else if (s1_i.eq) begin
      s2_d.ord = ORD_EQUAL;
    end else begin
      s2_d.ord = ORD_AFTER;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q <= s2_d;
    end
  end

  assign s2_o = s2_q;

endmodule

// File: design/gdc_wday_stage.sv
module gdc_wday_stage (
  input  logic              clk_i,
  input  logic              en3_i,
  input  logic              en4_i,
  input  gdc_pkg::gdc_s2_t  s2_i,
  output gdc_pkg::gdc_out_t out_o
);
  import gdc_pkg::*;

  gdc_s2_t              s3_q;
  logic [PROD7_W-1:0]   prod_q;
  logic [11:0]          q7;
  logic [13:0]          rem;
  gdc_out_t             out_d, out_q;

  // stage 3: reciprocal multiply for the mod-7
  always_ff @(posedge clk_i) begin
    if (en3_i) begin
      s3_q   <= s2_i;
      prod_q <= PROD7_W'(s2_i.cnt) * PROD7_W'(DIV7_MUL);
    end
  end

  // stage 4: remainder and zeroing of invalid dates
  always_comb begin
    q7  = prod_q[DIV7_SHIFT +: 12];
    rem = s3_q.cnt - 14'(q7) * 14'd7;
    out_d.date_valid    = s3_q.date_valid;
    out_d.ref_valid     = s3_q.ref_valid;
    out_d.day_of_year   = s3_q.date_valid ? s3_q.doy : 9'd0;
    out_d.days_in_month = s3_q.date_valid ? s3_q.dim : 5'd0;
    out_d.days_in_year  = s3_q.date_valid ? s3_q.diy : 9'd0;
    out_d.weekday       = s3_q.date_valid ? rem[2:0] : 3'd0;
    out_d.ordering      = s3_q.ord;
  end

  always_ff @(posedge clk_i) begin
    if (en4_i) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

// File: design/gregorian_date_calculator_core.sv
// Throughput: one request per cycle when the output is not stalled; four
// register stages (divide-by-100 multiplies, calendar decode, mod-7 multiply,
// remainder/output register). A stalled output holds the run of full stages
// that ends at the output; stages behind the first empty one still advance and fill.
// Reset (rst_ni low, asynchronous) clears the stage valid bits only.
module gregorian_date_calculator_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gdc_pkg::gdc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gdc_pkg::gdc_out_t out_data_o
);
  import gdc_pkg::*;

  logic [3:0] vld_q, vld_d;
  logic [3:0] adv;
  gdc_s1_t    s1;
  gdc_s2_t    s2;

  // a stage may load when it is empty or its content moves on
  always_comb begin
    adv[3] = !vld_q[3] || out_ready_i;
    adv[2] = !vld_q[2] || adv[3];
    adv[1] = !vld_q[1] || adv[2];
    adv[0] = !vld_q[0] || adv[1];
    vld_d[0] = adv[0] ? in_valid_i : vld_q[0];
    vld_d[1] = adv[1] ? vld_q[0]   : vld_q[1];
    vld_d[2] = adv[2] ? vld_q[1]   : vld_q[2];
    vld_d[3] = adv[3] ? vld_q[2]   : vld_q[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  gdc_div_stage u_div (
    .clk_i (clk_i),
    .en_i  (adv[0] && in_valid_i),
    .req_i (in_data_i),
    .s1_o  (s1)
  );

  gdc_cal_stage u_cal (
    .clk_i (clk_i),
    .en_i  (adv[1] && vld_q[0]),
    .s1_i  (s1),
    .s2_o  (s2)
  );

  gdc_wday_stage u_wday (
    .clk_i (clk_i),
    .en3_i (adv[2] && vld_q[1]),
    .en4_i (adv[3] && vld_q[2]),
    .s2_i  (s2),
    .out_o (out_data_o)
  );

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[3];

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.date_valid |->
      out_data_o.day_of_year == 9'd0 && out_data_o.weekday == 3'd0
      && out_data_o.ordering == ORD_INVALID)
    else $error("invalid date with nonzero results");

  a_valid_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.date_valid |->
      out_data_o.weekday <= 3'd6 && out_data_o.day_of_year != 9'd0
      && out_data_o.day_of_year <= out_data_o.days_in_year)
    else $error("valid date with results out of range");

  a_order_needs_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.ordering != ORD_INVALID |->
      out_data_o.date_valid && out_data_o.ref_valid)
    else $error("ordering given for an invalid date");

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q == 4'b1111 && !out_ready_i |=> vld_q == 4'b1111)
    else $error("full pipeline lost an entry under stall");

endmodule
